// File: rtl/core/sorted_priority_queue_macros.svh
// assertion macros for the sorted priority queue
// no dependencies; taken in by the rtl files that carry assertions
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies; used by the top level
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int COUNT_W      = 5;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        item_value;
    logic signed [31:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         out_value;
    logic signed [31:0]  out_priority;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
  } spq_out_t;

  // one stored entry
  typedef struct packed {
    logic [31:0]        value;
    logic signed [31:0] prio;
  } spq_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue.sv
// clear goes straight to the result state; insert, remove and search can walk over the held entries
// before the result is loaded into the output register
// throughput: one command at a time; the next transfer is taken once the result is in the output register
// the walk runs through the entry ram, at most one read and one write per cycle
// reset (synchronous, rst_n low): queue empty, sequencer idle, no result pending
// entry ram contents are not cleared; only slots below the held count are ever read
// depends on spq_pkg, spq_ram and sorted_priority_queue_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // command channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire spq_pkg::spq_in_t in_data,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output spq_pkg::spq_out_t     out_data
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = $bits(spq_pkg::spq_entry_t);

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,  // waiting for a command transfer
    S_INS    = 7'b0000010,  // insert: walk down from the tail, moving smaller entries up
    S_PUT    = 7'b0000100,  // insert: drop the new entry into its slot
    S_RHEAD  = 7'b0001000,  // remove: front entry arrives from the ram
    S_RSHIFT = 7'b0010000,  // remove: move the rest down by one
    S_SRCH   = 7'b0100000,  // search: compare one entry per cycle
    S_RESP   = 7'b1000000   // hand the result to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  spq_pkg::spq_in_t     item_r, item_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [31:0]          res_value_r, res_value_nxt;
  logic signed [31:0]   res_prio_r, res_prio_nxt;
  logic                 out_valid_r, out_valid_nxt;
  spq_pkg::spq_out_t    out_r, out_nxt;

  // entry ram port signals
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;

  spq_pkg::spq_entry_t  rd_entry;
  spq_pkg::spq_entry_t  new_entry;
  logic [IDX_W-1:0]     last_idx;
  logic [CNT_W-1:0]     ptr_ext_inc;
  logic                 prio_less;
  logic                 pair_match;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_entry            = spq_pkg::spq_entry_t'(rd_data);
  assign new_entry.value     = item_r.item_value;
  assign new_entry.prio      = item_r.item_priority;

  // index of the tail entry; only used while the queue holds something
  assign last_idx            = IDX_W'(count_r - CNT_W'(1));
  assign ptr_ext_inc         = CNT_W'(ptr_r) + CNT_W'(1);

  // compare logic fed by the ram read data: priority order for insert, exact match for search
  assign prio_less  = rd_entry.prio < item_r.item_priority;
  assign pair_match = (rd_entry.value == item_r.item_value) &&
                      (rd_entry.prio == item_r.item_priority);

  // busy from the accepted transfer until the result is loaded for output
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    item_nxt       = item_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_prio_nxt   = res_prio_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = new_entry;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          res_status_nxt = spq_pkg::ST_OK;
          res_value_nxt  = '0;
          res_prio_nxt   = '0;
          unique case (in_data.cmd)
            spq_pkg::CMD_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = spq_pkg::ST_FULL;
                state_nxt      = S_RESP;
              end else if (count_r == '0) begin
                // empty queue: the new entry goes straight to the front
                ptr_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                // start at the tail; target slot is one past it
                rd_en     = 1'b1;
                rd_addr   = last_idx;
                ptr_nxt   = IDX_W'(count_r);
                state_nxt = S_INS;
              end
            end
            spq_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = spq_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_RHEAD;
              end
            end
            spq_pkg::CMD_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = spq_pkg::ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            spq_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_INS: begin
        // rd_entry is the entry just below the target slot
        if (prio_less) begin
          // strictly lower priority moves up, so equal priorities keep arrival order
          wr_en   = 1'b1;
          wr_addr = ptr_r;
          wr_data = rd_data;
          ptr_nxt = ptr_r - IDX_W'(1);
          if (ptr_r == IDX_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_r - IDX_W'(2);
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = ptr_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_RESP;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      S_RHEAD: begin
        res_value_nxt = rd_entry.value;
        res_prio_nxt  = rd_entry.prio;
        if (count_r == CNT_W'(1)) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(1);
          ptr_nxt   = IDX_W'(1);
          state_nxt = S_RSHIFT;
        end
      end

      S_RSHIFT: begin
        // entry at ptr moves down one slot
        wr_en   = 1'b1;
        wr_addr = ptr_r - IDX_W'(1);
        wr_data = rd_data;
        if (ptr_ext_inc == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + IDX_W'(1);
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end

      S_SRCH: begin
        if (pair_match) begin
          res_status_nxt = spq_pkg::ST_OK;
          state_nxt      = S_RESP;
        end else if (ptr_ext_inc == count_r) begin
          res_status_nxt = spq_pkg::ST_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + IDX_W'(1);
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end

      S_RESP: begin
        // load once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = res_status_r;
          out_nxt.out_value    = res_value_r;
          out_nxt.out_priority = res_prio_r;
          out_nxt.entry_count  = spq_pkg::COUNT_W'(count_r);
          out_nxt.is_empty     = (count_r == '0);
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    item_r       <= item_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_prio_r   <= res_prio_nxt;
    out_r        <= out_nxt;
  end

  // held count stays within the store
  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "held count above capacity")

  // the ram is never written beyond one slot past the current tail
  `SPQ_ASSERT_NOW(a_write_in_range, clk, rst_n, wr_en, CNT_W'(wr_addr) <= count_r, "entry write beyond tail")

  // a command transfer always leaves idle
  `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE, "accepted command did not start")

  // a result appears only when the sequencer hands one over
  `SPQ_ASSERT_NEXT(a_result_source, clk, rst_n, !out_valid_r && state_r != S_RESP, !out_valid_r, "result without a command")

  // count moves by at most one per command, except clear
  `SPQ_ASSERT_NEXT(a_count_step, clk, rst_n, state_r != S_IDLE, count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1) || count_r == $past(count_r) - CNT_W'(1), "held count jumped")

endmodule

`default_nettype wire
